// ----- rtl/kpq_pkg.sv -----
`timescale 1ns / 1ps

package kpq_pkg;

   localparam int CFG_BITS           = 16;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam logic [CFG_BITS-1:0] LONG_HOLD_RESET    = 16'd300;
   localparam logic [CFG_BITS-1:0] CLEAR_HOLD_RESET   = 16'd200;
   localparam logic [CFG_BITS-1:0] CLEAR_RELOAD_RESET = 16'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LONG_HOLD    = 2'd0,
      REG_CLEAR_HOLD   = 2'd1,
      REG_CLEAR_RELOAD = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] long_hold_ticks;
      logic [CFG_BITS-1:0] clear_hold_ticks;
      logic [CFG_BITS-1:0] clear_reload_ticks;
   } cfg_type;

   typedef struct packed {
      logic set_level;
      logic up_level;
      logic av_level;
   } buttons_type;

   typedef struct packed {
      logic set_short;
      logic up_short;
      logic av_short;
      logic set_long;
      logic combo_long;
      logic trip_clear;
   } result_type;

endpackage

// ----- rtl/kpq_if.sv -----
`timescale 1ns / 1ps

interface kpq_req_if;
   logic valid;
   logic ready;
   logic set_level;
   logic up_level;
   logic av_level;

   modport source (output valid, output set_level, output up_level, output av_level,
                   input ready);
   modport sink   (input valid, input set_level, input up_level, input av_level,
                   output ready);
endinterface

interface kpq_rsp_if;
   logic valid;
   logic ready;
   logic set_short;
   logic up_short;
   logic av_short;
   logic set_long;
   logic combo_long;
   logic trip_clear;

   modport source (output valid, output set_short, output up_short, output av_short,
                   output set_long, output combo_long, output trip_clear, input ready);
   modport sink   (input valid, input set_short, input up_short, input av_short,
                   input set_long, input combo_long, input trip_clear, output ready);
endinterface

interface kpq_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kpq_pkg::CSR_INDEX_BITS-1:0] index;
   logic [kpq_pkg::CFG_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/key_press_and_hold_qualifier.sv -----
`timescale 1ns / 1ps
// An accepted tick's result is registered in the queue and offered from its head.
// Throughput: one tick per cycle while an entry is free; a two-entry queue keeps
// req_if.ready high while one result waits, and drops it only when both are full.
// Reset (synchronous): clears button history, cancels, hold counters and the queue;
// loads the hold and reload registers with their default values.

module key_press_and_hold_qualifier #(
   parameter int COUNT_BITS = kpq_pkg::COUNT_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   kpq_req_if.sink   req_if,
   kpq_rsp_if.source rsp_if,
   kpq_csr_if.sink   csr_if
);

   kpq_pkg::cfg_type     cfg;
   kpq_pkg::buttons_type buttons;
   kpq_pkg::result_type  result;
   kpq_pkg::result_type  rsp_data;
   logic                 queue_not_full;
   logic                 fire;

   assign buttons.set_level = req_if.set_level;
   assign buttons.up_level  = req_if.up_level;
   assign buttons.av_level  = req_if.av_level;
   assign req_if.ready      = queue_not_full;
   assign fire              = req_if.valid && queue_not_full;

   kpq_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   kpq_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .buttons (buttons),
      .cfg     (cfg),
      .result  (result)
   );

   kpq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (result),
      .pop       (rsp_if.valid && rsp_if.ready),
      .not_full  (queue_not_full),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_data)
   );

   assign rsp_if.set_short  = rsp_data.set_short;
   assign rsp_if.up_short   = rsp_data.up_short;
   assign rsp_if.av_short   = rsp_data.av_short;
   assign rsp_if.set_long   = rsp_data.set_long;
   assign rsp_if.combo_long = rsp_data.combo_long;
   assign rsp_if.trip_clear = rsp_data.trip_clear;

endmodule

// ----- rtl/kpq_csr_regs.sv -----
`timescale 1ns / 1ps

module kpq_csr_regs (
   input  logic             clock,
   input  logic             reset,
   kpq_csr_if.sink          csr_if,
   output kpq_pkg::cfg_type cfg
);

   kpq_pkg::cfg_type cfg_ff;
   kpq_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            kpq_pkg::REG_LONG_HOLD:    cfg_in.long_hold_ticks    = csr_if.data;
            kpq_pkg::REG_CLEAR_HOLD:   cfg_in.clear_hold_ticks   = csr_if.data;
            kpq_pkg::REG_CLEAR_RELOAD: cfg_in.clear_reload_ticks = csr_if.data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_hold_ticks    <= kpq_pkg::LONG_HOLD_RESET;
         cfg_ff.clear_hold_ticks   <= kpq_pkg::CLEAR_HOLD_RESET;
         cfg_ff.clear_reload_ticks <= kpq_pkg::CLEAR_RELOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/kpq_core.sv -----
`timescale 1ns / 1ps

module kpq_core #(
   parameter int COUNT_BITS = kpq_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  kpq_pkg::buttons_type buttons,
   input  kpq_pkg::cfg_type     cfg,
   output kpq_pkg::result_type  result
);

   localparam int CMP_BITS = (COUNT_BITS > kpq_pkg::CFG_BITS) ? COUNT_BITS : kpq_pkg::CFG_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic prev_set_ff, prev_up_ff, prev_av_ff;
   logic cancel_set_ff, cancel_up_ff, cancel_av_ff;
   logic cancel_set_in, cancel_up_in, cancel_av_in;
   logic [COUNT_BITS-1:0] set_hold_count_ff, set_hold_count_in;
   logic [COUNT_BITS-1:0] combo_hold_count_ff, combo_hold_count_in;
   logic [COUNT_BITS-1:0] clear_hold_count_ff, clear_hold_count_in;
   logic [COUNT_BITS-1:0] reload_sat;
   logic [CMP_BITS-1:0]   reload_ext;

   function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] count);
      return (count == CNT_MAX) ? CNT_MAX : count + COUNT_BITS'(1);
   endfunction

   assign reload_ext = CMP_BITS'(cfg.clear_reload_ticks);
   assign reload_sat = (reload_ext > CMP_BITS'(CNT_MAX)) ? CNT_MAX
                                                          : reload_ext[COUNT_BITS-1:0];

   always_comb begin
      result = '0;

      result.set_short = !buttons.set_level && prev_set_ff && !cancel_set_ff;
      result.up_short  = !buttons.up_level  && prev_up_ff  && !cancel_up_ff;
      result.av_short  = !buttons.av_level  && prev_av_ff  && !cancel_av_ff;

      cancel_set_in = (buttons.set_level != prev_set_ff) ? prev_set_ff : cancel_set_ff;
      cancel_up_in  = (buttons.up_level  != prev_up_ff)  ? prev_up_ff  : cancel_up_ff;
      cancel_av_in  = (buttons.av_level  != prev_av_ff)  ? prev_av_ff  : cancel_av_ff;

      set_hold_count_in = '0;
      if (buttons.set_level) begin
         if (CMP_BITS'(set_hold_count_ff) >= CMP_BITS'(cfg.long_hold_ticks)) begin
            cancel_set_in   = 1'b1;
            result.set_long = 1'b1;
         end else begin
            set_hold_count_in = inc_sat(set_hold_count_ff);
         end
      end

      combo_hold_count_in = '0;
      if (buttons.av_level && buttons.up_level) begin
         if (CMP_BITS'(combo_hold_count_ff) >= CMP_BITS'(cfg.long_hold_ticks)) begin
            cancel_av_in      = 1'b1;
            cancel_up_in      = 1'b1;
            result.combo_long = 1'b1;
         end else begin
            combo_hold_count_in = inc_sat(combo_hold_count_ff);
         end
      end

      clear_hold_count_in = clear_hold_count_ff;
      if (buttons.av_level && !buttons.up_level) begin
         if (CMP_BITS'(clear_hold_count_ff) >= CMP_BITS'(cfg.clear_hold_ticks)) begin
            cancel_av_in        = 1'b1;
            result.trip_clear   = 1'b1;
            clear_hold_count_in = reload_sat;
         end else begin
            clear_hold_count_in = inc_sat(clear_hold_count_ff);
         end
      end else if (clear_hold_count_ff != '0) begin
         clear_hold_count_in = clear_hold_count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_set_ff         <= 1'b0;
         prev_up_ff          <= 1'b0;
         prev_av_ff          <= 1'b0;
         cancel_set_ff       <= 1'b0;
         cancel_up_ff        <= 1'b0;
         cancel_av_ff        <= 1'b0;
         set_hold_count_ff   <= '0;
         combo_hold_count_ff <= '0;
         clear_hold_count_ff <= '0;
      end else if (fire) begin
         prev_set_ff         <= buttons.set_level;
         prev_up_ff          <= buttons.up_level;
         prev_av_ff          <= buttons.av_level;
         cancel_set_ff       <= cancel_set_in;
         cancel_up_ff        <= cancel_up_in;
         cancel_av_ff        <= cancel_av_in;
         set_hold_count_ff   <= set_hold_count_in;
         combo_hold_count_ff <= combo_hold_count_in;
         clear_hold_count_ff <= clear_hold_count_in;
      end
   end

endmodule

// ----- rtl/kpq_rsp_queue.sv -----
`timescale 1ns / 1ps

module kpq_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  kpq_pkg::result_type push_data,
   input  logic                pop,
   output logic                not_full,
   output logic                out_valid,
   output kpq_pkg::result_type out_data
);

   kpq_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/kpq_checker.sv -----
`timescale 1ns / 1ps

module kpq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic set_short,
   input logic up_short,
   input logic av_short,
   input logic set_long,
   input logic combo_long,
   input logic trip_clear
);

   logic [1:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_ff + {1'b0, req_take} - {1'b0, rsp_take};
      end
   end

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({set_short, up_short, av_short, set_long, combo_long, trip_clear}))
      else $error("stalled result changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result offered without an outstanding transaction");

   assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("input taken with two results outstanding");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(set_short && set_long) && !(combo_long && trip_clear) &&
         !(combo_long && (up_short || av_short)))
      else $error("result flags that exclude each other are both set");

endmodule

bind key_press_and_hold_qualifier kpq_checker u_kpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .set_short  (rsp_if.set_short),
   .up_short   (rsp_if.up_short),
   .av_short   (rsp_if.av_short),
   .set_long   (rsp_if.set_long),
   .combo_long (rsp_if.combo_long),
   .trip_clear (rsp_if.trip_clear)
);
